/* sv/lru_pkg.sv */
// Shared constants and types for the LRU page replacement block.
`default_nettype none
package lru_pkg;

    localparam int FRAMES = 16;
    localparam int SLOT_W = $clog2(FRAMES);
    localparam int BOUND_W = SLOT_W + 1;
    localparam int PAGE_W = 16;
    localparam int CNT_W = 32;
    localparam int CFG_W = 5;
    localparam int APB_DW = 32;
    localparam int APB_AW = 2;

    // Byte address of the frames_in_use register.
    localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = '0;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(FRAMES);
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    // Bound that lets every valid frame age by one (used when filling).
    localparam logic [BOUND_W-1:0] BOUND_ALL = BOUND_W'(FRAMES);

    // Update command from the sequencer to the frame table.
    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   slot;
        logic [BOUND_W-1:0]  bound;
        logic                set_valid;
        logic                write_page;
        logic [PAGE_W-1:0]   page;
    } upd_t;

    // Contents of one frame as seen by the scan.
    typedef struct packed {
        logic                valid;
        logic [PAGE_W-1:0]   page;
        logic [SLOT_W-1:0]   rank;
    } frame_t;

endpackage
`default_nettype wire

/* sv/lru_page_replacement.sv */
// Top level of the LRU page replacement block: sequencer, counters and ports.
`default_nettype none
// Each input transfer carries one page reference. The block scans the active
// frames (the first frames_in_use frames, where 0 counts as 1 and anything
// above 16 as 16) one frame per cycle through a single compare unit, looking
// at the same time for the first matching frame, the first empty frame and the
// least recently used frame. An update state then applies the decision: a hit
// makes its frame most recent, a miss fills the lowest empty frame or else
// replaces the least recently used one (ties go to the lowest index), and all
// other frames age accordingly. in_stall is high from acceptance until the
// decision has been applied, and a finished result sits in an output register
// so that the next reference can be accepted while the result still waits to
// be taken. If that register is still full when the next decision is ready,
// the block holds in the update state. Hit and miss totals saturate at all
// ones. Frames are not cleared when frames_in_use changes; frames outside the
// active range keep their contents but take no part in lookup or replacement.
// The register at byte address 0 holds frames_in_use and may only be written
// while idle; writes to any other address are ignored.
module lru_page_replacement (
    input  wire                          clk,
    input  wire                          rst_n,
    // APB-style configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [lru_pkg::APB_AW-1:0]    paddr,
    input  wire [lru_pkg::APB_DW-1:0]    pwdata,
    output logic [lru_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // Input channel
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire [lru_pkg::PAGE_W-1:0]    page_number,
    // Output channel
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic                         hit,
    output logic [lru_pkg::SLOT_W-1:0]   frame_slot,
    output logic                         evicted_valid,
    output logic [lru_pkg::PAGE_W-1:0]   evicted_page,
    output logic [lru_pkg::CNT_W-1:0]    hit_total,
    output logic [lru_pkg::CNT_W-1:0]    miss_total
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                       state_reg, state_next;
    logic [lru_pkg::CFG_W-1:0]    frames_reg, frames_next;
    logic [lru_pkg::SLOT_W-1:0]   idx_reg, idx_next;
    logic [lru_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic                         found_reg, found_next;
    logic [lru_pkg::SLOT_W-1:0]   found_slot_reg, found_slot_next;
    logic [lru_pkg::SLOT_W-1:0]   found_rank_reg, found_rank_next;
    logic                         empty_reg, empty_next;
    logic [lru_pkg::SLOT_W-1:0]   empty_slot_reg, empty_slot_next;
    logic [lru_pkg::SLOT_W-1:0]   best_slot_reg, best_slot_next;
    logic [lru_pkg::SLOT_W-1:0]   best_rank_reg, best_rank_next;
    logic [lru_pkg::PAGE_W-1:0]   best_page_reg, best_page_next;
    logic [lru_pkg::CNT_W-1:0]    hit_cnt_reg, hit_cnt_next;
    logic [lru_pkg::CNT_W-1:0]    miss_cnt_reg, miss_cnt_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         hit_reg, hit_next;
    logic [lru_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                         ev_valid_reg, ev_valid_next;
    logic [lru_pkg::PAGE_W-1:0]   ev_page_reg, ev_page_next;
    logic [lru_pkg::CNT_W-1:0]    hit_tot_reg, hit_tot_next;
    logic [lru_pkg::CNT_W-1:0]    miss_tot_reg, miss_tot_next;

    lru_pkg::frame_t              rd_frame;
    lru_pkg::upd_t                upd;
    logic [lru_pkg::SLOT_W-1:0]   last_idx;
    logic                         first;
    logic                         found_cur;
    logic                         empty_cur;
    logic                         match;
    logic                         out_free;

    lru_frame_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_frame (rd_frame),
        .upd      (upd)
    );

    // Configuration port: a single register, always ready.
    assign pready = 1'b1;
    assign prdata = lru_pkg::APB_DW'(frames_reg);

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign hit_total     = hit_tot_reg;
    assign miss_total    = miss_tot_reg;

    // The last frame index scanned, after clamping frames_in_use to 1..16.
    always_comb
    begin
        if (frames_reg == '0)
        begin
            last_idx = '0;
        end
        else if (frames_reg > lru_pkg::CFG_W'(lru_pkg::FRAMES))
        begin
            last_idx = lru_pkg::SLOT_W'(lru_pkg::FRAMES - 1);
        end
        else
        begin
            last_idx = lru_pkg::SLOT_W'(frames_reg - 1'b1);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // The scan state starts afresh at frame zero; these are the values of the
    // running flags as they stand before the frame under the read index.
    assign first     = (idx_reg == '0);
    assign found_cur = first ? 1'b0 : found_reg;
    assign empty_cur = first ? 1'b0 : empty_reg;
    assign match     = rd_frame.valid && (rd_frame.page == page_reg);

    always_comb
    begin
        state_next      = state_reg;
        frames_next     = frames_reg;
        idx_next        = idx_reg;
        page_next       = page_reg;
        found_next      = found_reg;
        found_slot_next = found_slot_reg;
        found_rank_next = found_rank_reg;
        empty_next      = empty_reg;
        empty_slot_next = empty_slot_reg;
        best_slot_next  = best_slot_reg;
        best_rank_next  = best_rank_reg;
        best_page_next  = best_page_reg;
        hit_cnt_next    = hit_cnt_reg;
        miss_cnt_next   = miss_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        ev_valid_next   = ev_valid_reg;
        ev_page_next    = ev_page_reg;
        hit_tot_next    = hit_tot_reg;
        miss_tot_next   = miss_tot_reg;
        upd             = '0;

        if (psel && penable && pwrite && (paddr == lru_pkg::ADDR_FRAMES_IN_USE))
        begin
            frames_next = pwdata[lru_pkg::CFG_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    page_next  = page_number;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // One frame per cycle through the shared compare unit.
                found_next = found_cur;
                empty_next = empty_cur;
                if (!found_cur && match)
                begin
                    found_next      = 1'b1;
                    found_slot_next = idx_reg;
                    found_rank_next = rd_frame.rank;
                end
                if (!empty_cur && !rd_frame.valid)
                begin
                    empty_next      = 1'b1;
                    empty_slot_next = idx_reg;
                end
                if (first || (rd_frame.rank > best_rank_reg))
                begin
                    best_slot_next = idx_reg;
                    best_rank_next = rd_frame.rank;
                    best_page_next = rd_frame.page;
                end
                if (idx_reg == last_idx)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_UPDATE:
            begin
                // Wait for the output register before committing anything.
                if (out_free)
                begin
                    upd.en         = 1'b1;
                    upd.page       = page_reg;
                    out_valid_next = 1'b1;
                    hit_next       = found_reg;
                    ev_valid_next  = 1'b0;
                    ev_page_next   = '0;
                    if (found_reg)
                    begin
                        upd.slot  = found_slot_reg;
                        upd.bound = {1'b0, found_rank_reg};
                        if (hit_cnt_reg != lru_pkg::CNT_MAX)
                        begin
                            hit_cnt_next = hit_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        upd.write_page = 1'b1;
                        if (empty_reg)
                        begin
                            upd.slot      = empty_slot_reg;
                            upd.bound     = lru_pkg::BOUND_ALL;
                            upd.set_valid = 1'b1;
                        end
                        else
                        begin
                            upd.slot      = best_slot_reg;
                            upd.bound     = {1'b0, best_rank_reg};
                            ev_valid_next = 1'b1;
                            ev_page_next  = best_page_reg;
                        end
                        if (miss_cnt_reg != lru_pkg::CNT_MAX)
                        begin
                            miss_cnt_next = miss_cnt_reg + 1'b1;
                        end
                    end
                    slot_next     = upd.slot;
                    hit_tot_next  = hit_cnt_next;
                    miss_tot_next = miss_cnt_next;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            frames_reg    <= lru_pkg::FRAMES_IN_USE_RESET;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            empty_reg     <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frames_reg    <= frames_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            empty_reg     <= empty_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg       <= page_next;
        found_slot_reg <= found_slot_next;
        found_rank_reg <= found_rank_next;
        empty_slot_reg <= empty_slot_next;
        best_slot_reg  <= best_slot_next;
        best_rank_reg  <= best_rank_next;
        best_page_reg  <= best_page_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        ev_valid_reg   <= ev_valid_next;
        ev_page_reg    <= ev_page_next;
        hit_tot_reg    <= hit_tot_next;
        miss_tot_reg   <= miss_tot_next;
    end

endmodule
`default_nettype wire

/* sv/lru_frame_table.sv */
// Frame table: pages, valid flags and recency ranks with one scan read port.
`default_nettype none
module lru_frame_table (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire [lru_pkg::SLOT_W-1:0]  rd_idx,
    output lru_pkg::frame_t            rd_frame,
    input  wire lru_pkg::upd_t         upd
);

    logic [lru_pkg::PAGE_W-1:0] page_reg [lru_pkg::FRAMES];
    logic [lru_pkg::SLOT_W-1:0] rank_reg [lru_pkg::FRAMES];
    logic [lru_pkg::FRAMES-1:0] valid_reg;

    always_comb
    begin
        rd_frame.valid = valid_reg[rd_idx];
        rd_frame.page  = page_reg[rd_idx];
        rd_frame.rank  = rank_reg[rd_idx];
    end

    // On an update the chosen frame becomes most recent; every other valid
    // frame younger than the bound ages by one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int k = 0; k < lru_pkg::FRAMES; k++)
            begin
                page_reg[k] <= '0;
                rank_reg[k] <= '0;
            end
        end
        else if (upd.en)
        begin
            for (int k = 0; k < lru_pkg::FRAMES; k++)
            begin
                if (upd.slot == lru_pkg::SLOT_W'(k))
                begin
                    rank_reg[k] <= '0;
                    if (upd.set_valid)
                    begin
                        valid_reg[k] <= 1'b1;
                    end
                    if (upd.write_page)
                    begin
                        page_reg[k] <= upd.page;
                    end
                end
                else if (valid_reg[k] && ({1'b0, rank_reg[k]} < upd.bound))
                begin
                    rank_reg[k] <= rank_reg[k] + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire
